FILE: rtl/cdq_pkg.sv
// Package for the circular deque: operation and status codes, word type.
// Used by cdq_store and circular_deque; depends on nothing.
package cdq_pkg;

  localparam int WORD_W   = 32;
  localparam int ACTION_W = 2;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 8;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [ACTION_W-1:0]      action_t;
  typedef logic [STATUS_W-1:0]      status_t;

  localparam action_t ACT_PUSH_FRONT = 2'd0;
  localparam action_t ACT_PUSH_REAR  = 2'd1;
  localparam action_t ACT_POP_FRONT  = 2'd2;
  localparam action_t ACT_POP_REAR   = 2'd3;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  localparam word_t EMPTY_WORD = -32'sd1;

endpackage

FILE: rtl/cdq_store.sv
// Word store of the circular deque: one write port, one read port with
// registered read data. Depends on cdq_pkg.
module cdq_store #(
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  cdq_pkg::word_t           wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output cdq_pkg::word_t           rd_data
);
  import cdq_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/circular_deque.sv
// Top level of the circular deque: pointer and count control, output register.
// Depends on cdq_pkg and cdq_store.

// A double-ended queue of signed 32-bit words held in a circular memory of
// DEPTH entries. Each input transaction carries an operation in s_tuser (push
// front, push rear, pop front, pop rear) and, for pushes, the word in s_tdata.
// Every operation returns exactly one output transaction with the popped word,
// a status (done, refused because full, refused because empty) and the number
// of words held afterwards. Pushes, and any refused operation, can be accepted
// back to back while the result side is ready. A successful pop holds off the
// next transaction, because the word comes out of the memory's registered read
// port and is then loaded into the output register. The output register lets a
// new transaction be accepted in the same cycle in which the waiting result is
// taken. No clearing pass is needed after reset: only pushed entries are read.
module circular_deque #(
  parameter int DEPTH = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] data_in
  input  logic [1:0]  s_tuser,   // [1:0] action
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] data_out, [39:32] occupancy
  output logic [1:0]  m_tuser    // [1:0] status
);
  import cdq_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Architectural state: the memory holds the words, these registers hold the
  // positions of the front and rear words and the number of words stored.
  logic [IDX_W-1:0] head_index, head_index_next;
  logic [IDX_W-1:0] tail_index, tail_index_next;
  logic [CNT_W-1:0] count, count_next;

  // busy is high in the cycle in which a popped word is being read.
  logic busy;

  logic      accept;
  action_t   action;
  word_t     data_in;
  logic      is_push;
  logic      is_empty;
  logic      is_full;
  logic      pop_ok;
  status_t   res_status;
  word_t     res_data;

  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;
  word_t            rd_data;

  // Output register.
  word_t            data_out;
  status_t          status;
  logic [OCC_W-1:0] occupancy;

  assign action   = action_t'(s_tuser);
  assign data_in  = word_t'(s_tdata);
  assign is_push  = action inside {ACT_PUSH_FRONT, ACT_PUSH_REAR};
  assign is_empty = (count == '0);
  assign is_full  = (count == FULL_CNT);
  assign pop_ok   = !is_push && !is_empty;

  // A new transaction is taken when no pop is in flight and the output register
  // is free, or is being emptied in this cycle.
  assign s_tready = !busy && (!m_tvalid || m_tready);
  assign accept   = s_tvalid && s_tready;

  // Next-state logic for one operation. Writes and reads go to the entry that
  // the updated (push) or current (pop) pointer names.
  always_comb begin
    head_index_next = head_index;
    tail_index_next = tail_index;
    count_next      = count;
    wr_en           = 1'b0;
    wr_addr         = '0;
    rd_addr         = head_index;
    res_status      = ST_DONE;
    res_data        = '0;
    case (action)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (is_full) begin
          res_status = ST_FULL;
        end else begin
          wr_en      = accept;
          count_next = count + 1'b1;
          if (is_empty) begin
            // The first word always lands in entry zero.
            head_index_next = '0;
            tail_index_next = '0;
            wr_addr         = '0;
          end else if (action == ACT_PUSH_FRONT) begin
            head_index_next = (head_index == '0) ? LAST_IDX : head_index - 1'b1;
            wr_addr         = head_index_next;
          end else begin
            tail_index_next = (tail_index == LAST_IDX) ? '0 : tail_index + 1'b1;
            wr_addr         = tail_index_next;
          end
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (is_empty) begin
          res_status = ST_EMPTY;
          res_data   = EMPTY_WORD;
        end else begin
          count_next = count - 1'b1;
          rd_addr    = (action == ACT_POP_FRONT) ? head_index : tail_index;
          if (count == CNT_W'(1)) begin
            // Taking the last word sends both pointers back to zero.
            head_index_next = '0;
            tail_index_next = '0;
          end else if (action == ACT_POP_FRONT) begin
            head_index_next = (head_index == LAST_IDX) ? '0 : head_index + 1'b1;
          end else begin
            tail_index_next = (tail_index == '0) ? LAST_IDX : tail_index - 1'b1;
          end
        end
      end
      default: begin
        res_status = ST_DONE;
      end
    endcase
  end

  cdq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (data_in),
    .rd_en   (accept && pop_ok),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // The pointers and count move at the accepting edge, so the next transaction
  // always sees the state left by this one. A pop reads the memory at the same
  // edge, after any write of the previous cycle has landed.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      tail_index <= '0;
      count      <= '0;
      busy       <= 1'b0;
    end else begin
      busy <= accept && pop_ok;
      if (accept) begin
        head_index <= head_index_next;
        tail_index <= tail_index_next;
        count      <= count_next;
      end
    end
  end

  // Output register. A successful pop loads it in the cycle after acceptance with
  // the word from memory; by then the register is known to be empty.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (busy) begin
      m_tvalid <= 1'b1;
    end else if (accept && !pop_ok) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      data_out  <= rd_data;
      status    <= ST_DONE;
      occupancy <= OCC_W'(count);
    end else if (accept && !pop_ok) begin
      data_out  <= res_data;
      status    <= res_status;
      occupancy <= OCC_W'(count_next);
    end
  end

  assign m_tdata = {occupancy, data_out};
  assign m_tuser = status;

  // The count never goes beyond the capacity.
  assert property (@(posedge clk) disable iff (rst) count <= FULL_CNT)
    else $error("deque count exceeds capacity");

  // An empty deque keeps both pointers at entry zero.
  assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> (head_index == '0) && (tail_index == '0))
    else $error("pointers not at zero while deque is empty");

  // While a popped word is being read the output register must be free.
  assert property (@(posedge clk) disable iff (rst) busy |-> !m_tvalid)
    else $error("pop result would overwrite a waiting result");

  // An accepted push into a deque with room raises the count by one.
  assert property (@(posedge clk) disable iff (rst)
    accept && is_push && !is_full |=> count == $past(count) + 1'b1)
    else $error("push did not raise the count");

  // A refused pop reports the empty marker and no words held.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status == ST_EMPTY) |-> (data_out == EMPTY_WORD) && (occupancy == '0))
    else $error("empty pop result malformed");

endmodule

FILE: bench/circular_deque_tb.sv
// Self-checking testbench for circular_deque: directed corner cases, then fill,
// drain and mixed random traffic with random idling on both streams.
// Depends on cdq_pkg and the circular_deque RTL.
`timescale 1ns / 1ps

module circular_deque_tb;
  import cdq_pkg::*;

  localparam int DEPTH = 128;

  // One predicted output transaction of the deque.
  typedef struct {
    word_t         data;
    status_t       status;
    logic [OCC_W-1:0] occupancy;
  } deque_result_t;

  // Traffic shapes for the random part.
  typedef enum {SHAPE_FILL, SHAPE_MIX, SHAPE_DRAIN} traffic_shape_t;

  // Mirrors the deque contents and keeps the results still to come, oldest first.
  class deque_scoreboard;
    word_t         words[DEPTH];
    int            head;
    int            tail;
    int            count;
    deque_result_t predicted_q[$];
    int            mismatches;

    function new();
      head = 0;
      tail = 0;
      count = 0;
      mismatches = 0;
    endfunction

    // Applies one accepted operation to the mirror and queues its result.
    function void note_operation(action_t act, word_t w);
      deque_result_t r;
      r.data = '0;
      r.status = ST_DONE;
      case (act)
        ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            if (count == 0) begin
              head = 0;
              tail = 0;
              words[0] = w;
            end else if (act == ACT_PUSH_FRONT) begin
              head = (head == 0) ? DEPTH - 1 : head - 1;
              words[head] = w;
            end else begin
              tail = (tail == DEPTH - 1) ? 0 : tail + 1;
              words[tail] = w;
            end
            count++;
          end
        end
        default: begin
          if (count == 0) begin
            r.data = EMPTY_WORD;
            r.status = ST_EMPTY;
          end else begin
            r.data = (act == ACT_POP_FRONT) ? words[head] : words[tail];
            if (count == 1) begin
              head = 0;
              tail = 0;
            end else if (act == ACT_POP_FRONT) begin
              head = (head == DEPTH - 1) ? 0 : head + 1;
            end else begin
              tail = (tail == 0) ? DEPTH - 1 : tail - 1;
            end
            count--;
          end
        end
      endcase
      r.occupancy = count[OCC_W-1:0];
      predicted_q.push_back(r);
    endfunction

    // Compares one output transaction with the oldest prediction.
    function void check_result(word_t data, status_t status, logic [OCC_W-1:0] occupancy);
      deque_result_t r;
      if (predicted_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result data=%0d status=%0d occupancy=%0d",
                   $realtime, data, status, occupancy);
        mismatches++;
        return;
      end
      r = predicted_q.pop_front();
      if (data !== r.data || status !== r.status || occupancy !== r.occupancy) begin
        if (mismatches < 10) begin
          $display("%0t: mismatch, expected data=%0d status=%0d occupancy=%0d",
                   $realtime, r.data, r.status, r.occupancy);
          $display("    got data=%0d status=%0d occupancy=%0d", data, status, occupancy);
        end
        mismatches++;
      end
    endfunction

    function int outstanding();
      return predicted_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] data_in
  logic [1:0]  s_tuser = '0;   // [1:0] action
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;        // [31:0] data_out, [39:32] occupancy
  logic [1:0]  m_tuser;        // [1:0] status

  deque_scoreboard sb = new();
  // While set, neither side idles, so back-to-back transactions are exercised.
  bit quiet = 1'b0;

  circular_deque #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 18);
  endfunction

  // Mostly random words, with the extremes turning up now and then.
  function automatic word_t draw_word();
    case ($urandom_range(0, 15))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      default: return word_t'($urandom());
    endcase
  endfunction

  // Drives one operation and returns at the edge where it is accepted. Valid
  // stays high across back-to-back transactions and is lowered only for an idle gap.
  task automatic send_operation(action_t act, word_t w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= w;
    do @(posedge clk); while (!s_tready);
    sb.note_operation(act, w);
  endtask

  task automatic run_directed();
    // Pops from an empty deque, at both ends.
    send_operation(ACT_POP_FRONT, 32'sd7);
    send_operation(ACT_POP_REAR, -32'sd7);
    // The first push lands in entry zero; the next front push wraps the head.
    send_operation(ACT_PUSH_FRONT, 32'sh7FFF_FFFF);
    send_operation(ACT_PUSH_FRONT, 32'sh8000_0000);
    send_operation(ACT_PUSH_REAR, '0);
    send_operation(ACT_PUSH_REAR, -32'sd1);
    send_operation(ACT_POP_FRONT, '0);
    send_operation(ACT_POP_REAR, '0);
    send_operation(ACT_POP_FRONT, '0);
    // Popping the last word sends both indices back to zero.
    send_operation(ACT_POP_REAR, '0);
    send_operation(ACT_POP_REAR, '0);
    send_operation(ACT_PUSH_REAR, 32'sh5555_AAAA);
    send_operation(ACT_PUSH_FRONT, 32'shAAAA_5555);
    send_operation(ACT_PUSH_REAR, 32'sh1234_5678);
    send_operation(ACT_POP_REAR, '0);
    send_operation(ACT_POP_REAR, '0);
    send_operation(ACT_POP_REAR, '0);
    send_operation(ACT_POP_FRONT, '0);
  endtask

  // Fill and drain stretches push the deque to full and back to empty, so
  // refused pushes, refused pops and index wrap all come round repeatedly.
  task automatic run_random(int total);
    traffic_shape_t shape;
    int sent;
    int stretch;
    int favoured;
    bit is_push;
    action_t act;
    sent = 0;
    shape = SHAPE_FILL;
    while (sent < total) begin
      quiet = ($urandom_range(0, 3) == 0);
      stretch = (shape == SHAPE_MIX) ? $urandom_range(30, 80) : $urandom_range(150, 190);
      for (int i = 0; i < stretch && sent < total; i++) begin
        favoured = $urandom_range(0, 19);
        case (shape)
          SHAPE_FILL:  is_push = (favoured != 0);
          SHAPE_DRAIN: is_push = (favoured == 0);
          default:     is_push = (favoured < 10);
        endcase
        if (is_push)
          act = $urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR;
        else
          act = $urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR;
        send_operation(act, draw_word());
        sent++;
      end
      case (shape)
        SHAPE_FILL:  shape = SHAPE_MIX;
        SHAPE_MIX:   shape = (sb.count > DEPTH / 2) ? SHAPE_DRAIN : SHAPE_FILL;
        default:     shape = SHAPE_MIX;
      endcase
    end
    quiet = 1'b0;
    s_tvalid <= 1'b0;
  endtask

  // Result side: ready idles at random, and each result is checked at the
  // edge where it is taken.
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(word_t'(m_tdata[31:0]), status_t'(m_tuser), m_tdata[39:32]);
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    run_random(700);
    // Let the outstanding results drain, then allow for the pop path through the memory.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
